FILE: sv/gsht_pkg.sv
`timescale 1ns / 1ps
// Package for the glyph slot hash table: field widths, character range constants,
// opcode and status codes. Depends on nothing.
package gsht_pkg;

    localparam int OPCODE_W = 2;
    localparam int CODE_W   = 21;
    localparam int STYLE_W  = 2;
    localparam int SLOT_W   = 14;
    localparam int STATUS_W = 2;
    localparam int PROBE_W  = 15;

    // Printable codes from space to tilde map straight onto the first slots.
    localparam int                DIRECT_SLOTS = 95;
    localparam logic [CODE_W-1:0] CHAR_FIRST   = CODE_W'(32);
    localparam logic [CODE_W-1:0] CHAR_LAST    = CODE_W'(126);

    typedef enum logic [OPCODE_W-1:0] {
        OP_LOOKUP = 2'd0,
        OP_MARK   = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NONE   = 2'd3
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_LOADED    = 2'd0,
        ST_NEED_LOAD = 2'd1,
        ST_FULL      = 2'd2,
        ST_DONE      = 2'd3
    } t_status;

endpackage

FILE: sv/gsht_slot_mem.sv
`timescale 1ns / 1ps
// Slot memory of the glyph slot hash table: one write port and one registered read port.
// Depends on no package.
module gsht_slot_mem #(
    parameter int DEPTH = 16384,
    parameter int WIDTH = 25
) (
    input  logic                     i_clk,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: sv/gsht_hash.sv
`timescale 1ns / 1ps
// Home slot calculation: 95 plus the code modulo the hashed slot count, by a reciprocal
// multiply with one correction step. Depends on gsht_pkg.
module gsht_hash import gsht_pkg::*; #(
    parameter int TABLE_SLOTS = 16384
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [CODE_W-1:0]              i_code_point,
    output logic                           o_done,
    output logic [$clog2(TABLE_SLOTS)-1:0] o_slot
);

    localparam int          AW     = $clog2(TABLE_SLOTS);
    localparam int          HASHED = TABLE_SLOTS - DIRECT_SLOTS;
    localparam logic [63:0] RECIP  = (64'd1 << 32) / 64'(HASHED);
    localparam int          RW     = $clog2(RECIP + 64'd1);
    localparam int          PRODW  = CODE_W + RW;
    localparam int          QW     = PRODW - 32;
    localparam int          DW     = $clog2(HASHED + 1);
    localparam int          QDW    = QW + DW;

    logic [1:0]        r_vld;
    logic [CODE_W-1:0] r_code1;
    logic [PRODW-1:0]  r_prod;
    logic [CODE_W-1:0] r_code2;
    logic [CODE_W-1:0] r_qd;

    logic [QW-1:0]     w_q;
    logic [QDW-1:0]    w_qd;
    logic [CODE_W-1:0] w_rem;
    logic [CODE_W-1:0] w_rem_fix;

    // The estimated quotient is either exact or one short, so one subtract settles it.
    assign w_q       = r_prod[PRODW-1:32];
    assign w_qd      = QDW'(w_q) * QDW'(HASHED);
    assign w_rem     = r_code2 - r_qd;
    assign w_rem_fix = (w_rem >= CODE_W'(HASHED)) ? (w_rem - CODE_W'(HASHED)) : w_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[0], i_start};
        end
    end

    always_ff @(posedge i_clk) begin
        r_code1 <= i_code_point;
        r_prod  <= PRODW'(i_code_point) * PRODW'(RECIP[RW-1:0]);
        r_code2 <= r_code1;
        r_qd    <= CODE_W'(w_qd);
    end

    assign o_done = r_vld[1];
    assign o_slot = AW'(w_rem_fix) + AW'(DIRECT_SLOTS);

endmodule

FILE: sv/glyph_slot_hash_table.sv
`timescale 1ns / 1ps
// Top level of the glyph slot hash table: control sequencer, result register and the
// slot memory and hash units. Depends on gsht_pkg, gsht_slot_mem and gsht_hash.
//
// The table holds TABLE_SLOTS entries of a 21-bit key and one loaded bit per style in a
// single synchronous memory, and works on one transaction at a time. After reset the
// block sweeps the memory to zero, one slot a cycle, and holds o_in_stall high until
// the sweep ends. A lookup of a printable code (space to tilde) passes acceptance, one
// memory read, the check and the hand-over to the result register. Any other code first
// passes the two-stage reciprocal multiply that gives its home slot, and each collision
// adds a read and then a compare. A mark is a read-modify-write of one slot; a clear
// walks every slot. The memory port is the limit throughout: every probe is a read
// followed by a compare of its registered data. A finished result sits in the output
// register, so a new transaction is taken while the previous result still waits to be
// collected.
module glyph_slot_hash_table import gsht_pkg::*; #(
    parameter int TABLE_SLOTS = 16384,
    parameter int STYLE_COUNT = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Request channel
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [OPCODE_W-1:0] i_opcode,
    input  logic [CODE_W-1:0]   i_code_point,
    input  logic [STYLE_W-1:0]  i_style,
    input  logic [SLOT_W-1:0]   i_target_slot,
    // Result channel
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [SLOT_W-1:0]   o_slot_index,
    output logic [STATUS_W-1:0] o_status,
    output logic [PROBE_W-1:0]  o_probe_count
);

    localparam int AW      = $clog2(TABLE_SLOTS);
    localparam int PW      = $clog2(TABLE_SLOTS + 1);
    localparam int MW      = STYLE_COUNT;
    localparam int ENTRY_W = CODE_W + MW;

    typedef enum logic [7:0] {
        S_CLEAR   = 8'b0000_0001,
        S_IDLE    = 8'b0000_0010,
        S_HASH    = 8'b0000_0100,
        S_READ    = 8'b0000_1000,
        S_CHECK   = 8'b0001_0000,
        S_MARK_RD = 8'b0010_0000,
        S_MARK_WR = 8'b0100_0000,
        S_DONE    = 8'b1000_0000
    } t_state;

    // Control registers
    t_state r_state, n_state;
    logic   r_clr_op, n_clr_op;
    logic   r_o_valid, n_o_valid;
    logic [AW-1:0] r_clr_cnt, n_clr_cnt;

    // Transaction payload and working registers
    logic [CODE_W-1:0]  r_code, n_code;
    logic [STYLE_W-1:0] r_style, n_style;
    logic [AW-1:0]      r_slot, n_slot;
    logic [PW-1:0]      r_probes, n_probes;
    logic               r_direct, n_direct;
    logic [SLOT_W-1:0]  r_res_slot, n_res_slot;
    t_status            r_res_status, n_res_status;
    logic [PROBE_W-1:0] r_res_probes, n_res_probes;
    logic [SLOT_W-1:0]  r_o_slot, n_o_slot;
    t_status            r_o_status, n_o_status;
    logic [PROBE_W-1:0] r_o_probes, n_o_probes;

    // Memory and hash unit connections
    logic               w_rd_en;
    logic [AW-1:0]      w_rd_addr;
    logic [ENTRY_W-1:0] w_rd_data;
    logic               w_wr_en;
    logic [AW-1:0]      w_wr_addr;
    logic [ENTRY_W-1:0] w_wr_data;
    logic               w_hash_start;
    logic               w_hash_done;
    logic [AW-1:0]      w_hash_slot;

    logic [CODE_W-1:0]  w_key;
    logic [MW-1:0]      w_marks;
    logic [MW-1:0]      w_marks_shift;
    logic               w_style_ok;
    logic               w_in_style_ok;
    logic               w_target_ok;
    logic               w_is_direct;
    logic               w_out_free;
    logic [PW-1:0]      w_probes_inc;
    logic [AW-1:0]      w_slot_next;
    t_status            w_hit_status;

    gsht_slot_mem #(
        .DEPTH (TABLE_SLOTS),
        .WIDTH (ENTRY_W)
    ) u_slot_mem (
        .i_clk     (i_clk),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data)
    );

    gsht_hash #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_hash (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (w_hash_start),
        .i_code_point (i_code_point),
        .o_done       (w_hash_done),
        .o_slot       (w_hash_slot)
    );

    // The entry holds the key in its upper bits and the loaded marks in its lower bits.
    assign w_key         = w_rd_data[ENTRY_W-1:MW];
    assign w_marks       = w_rd_data[MW-1:0];
    assign w_marks_shift = w_marks >> r_style;
    assign w_style_ok    = ({30'd0, r_style} < 32'(STYLE_COUNT));
    assign w_hit_status  = (w_style_ok && w_marks_shift[0]) ? ST_LOADED : ST_NEED_LOAD;

    assign w_in_style_ok = ({30'd0, i_style} < 32'(STYLE_COUNT));
    assign w_target_ok   = ({18'd0, i_target_slot} < 32'(TABLE_SLOTS));
    assign w_is_direct   = (i_code_point >= CHAR_FIRST) && (i_code_point <= CHAR_LAST);

    // Linear probing wraps from the last slot back to the first hashed slot.
    assign w_probes_inc = r_probes + PW'(1);
    assign w_slot_next  = (r_slot == AW'(TABLE_SLOTS - 1)) ? AW'(DIRECT_SLOTS)
                                                          : r_slot + AW'(1);

    // The result register may be loaded when it is empty or being emptied this cycle.
    assign w_out_free = !r_o_valid || !i_out_stall;

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state      = r_state;
        n_clr_op     = r_clr_op;
        n_clr_cnt    = r_clr_cnt;
        n_o_valid    = r_o_valid;
        n_code       = r_code;
        n_style      = r_style;
        n_slot       = r_slot;
        n_probes     = r_probes;
        n_direct     = r_direct;
        n_res_slot   = r_res_slot;
        n_res_status = r_res_status;
        n_res_probes = r_res_probes;
        n_o_slot     = r_o_slot;
        n_o_status   = r_o_status;
        n_o_probes   = r_o_probes;
        w_rd_en      = 1'b0;
        w_rd_addr    = r_slot;
        w_wr_en      = 1'b0;
        w_wr_addr    = r_slot;
        w_wr_data    = '0;
        w_hash_start = 1'b0;

        if (r_o_valid && !i_out_stall) begin
            n_o_valid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                // Zero one slot a cycle; the clear after reset ends without a result.
                w_wr_en   = 1'b1;
                w_wr_addr = r_clr_cnt;
                w_wr_data = '0;
                if (r_clr_cnt == AW'(TABLE_SLOTS - 1)) begin
                    n_clr_cnt = '0;
                    if (r_clr_op) begin
                        n_clr_op     = 1'b0;
                        n_res_slot   = '0;
                        n_res_status = ST_DONE;
                        n_res_probes = '0;
                        n_state      = S_DONE;
                    end else begin
                        n_state = S_IDLE;
                    end
                end else begin
                    n_clr_cnt = r_clr_cnt + AW'(1);
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_code   = i_code_point;
                    n_style  = i_style;
                    n_probes = '0;
                    case (t_opcode'(i_opcode))
                        OP_LOOKUP: begin
                            if (w_is_direct) begin
                                n_slot   = AW'(i_code_point - CHAR_FIRST);
                                n_direct = 1'b1;
                                n_state  = S_READ;
                            end else begin
                                n_direct     = 1'b0;
                                w_hash_start = 1'b1;
                                n_state      = S_HASH;
                            end
                        end
                        OP_MARK: begin
                            n_res_slot   = i_target_slot;
                            n_res_status = ST_DONE;
                            n_res_probes = '0;
                            n_slot       = AW'(i_target_slot);
                            if (w_target_ok && w_in_style_ok) begin
                                n_state = S_MARK_RD;
                            end else begin
                                n_state = S_DONE;
                            end
                        end
                        OP_CLEAR: begin
                            n_clr_op  = 1'b1;
                            n_clr_cnt = '0;
                            n_state   = S_CLEAR;
                        end
                        default: begin
                            n_res_slot   = '0;
                            n_res_status = ST_DONE;
                            n_res_probes = '0;
                            n_state      = S_DONE;
                        end
                    endcase
                end
            end
            S_HASH: begin
                if (w_hash_done) begin
                    n_slot  = w_hash_slot;
                    n_state = S_READ;
                end
            end
            S_READ: begin
                w_rd_en   = 1'b1;
                w_rd_addr = r_slot;
                n_state   = S_CHECK;
            end
            S_CHECK: begin
                // A matching key wins over an empty slot, so code zero stops at the
                // first empty slot without claiming it.
                if (r_direct || (w_key == r_code)) begin
                    n_res_slot   = SLOT_W'(r_slot);
                    n_res_status = w_hit_status;
                    n_res_probes = PROBE_W'(r_probes);
                    n_state      = S_DONE;
                end else if (w_key == '0) begin
                    // Claim the slot; its marks are cleared so no stale style carries over.
                    w_wr_en      = 1'b1;
                    w_wr_addr    = r_slot;
                    w_wr_data    = {r_code, {MW{1'b0}}};
                    n_res_slot   = SLOT_W'(r_slot);
                    n_res_status = ST_NEED_LOAD;
                    n_res_probes = PROBE_W'(r_probes);
                    n_state      = S_DONE;
                end else if (w_probes_inc == PW'(TABLE_SLOTS)) begin
                    n_res_slot   = '0;
                    n_res_status = ST_FULL;
                    n_res_probes = PROBE_W'(w_probes_inc);
                    n_state      = S_DONE;
                end else begin
                    n_probes = w_probes_inc;
                    n_slot   = w_slot_next;
                    n_state  = S_READ;
                end
            end
            S_MARK_RD: begin
                w_rd_en   = 1'b1;
                w_rd_addr = r_slot;
                n_state   = S_MARK_WR;
            end
            S_MARK_WR: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_slot;
                w_wr_data = {w_key, w_marks | (MW'(1) << r_style)};
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_o_valid  = 1'b1;
                    n_o_slot   = r_res_slot;
                    n_o_status = r_res_status;
                    n_o_probes = r_res_probes;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr_op  <= 1'b0;
            r_clr_cnt <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr_op  <= n_clr_op;
            r_clr_cnt <= n_clr_cnt;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_code       <= n_code;
        r_style      <= n_style;
        r_slot       <= n_slot;
        r_probes     <= n_probes;
        r_direct     <= n_direct;
        r_res_slot   <= n_res_slot;
        r_res_status <= n_res_status;
        r_res_probes <= n_res_probes;
        r_o_slot     <= n_o_slot;
        r_o_status   <= n_o_status;
        r_o_probes   <= n_o_probes;
    end

    assign o_out_valid   = r_o_valid;
    assign o_slot_index  = r_o_slot;
    assign o_status      = r_o_status;
    assign o_probe_count = r_o_probes;

endmodule
